// ===== design/assert_macros.svh =====
// Assertion macros shared by the interpolator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk_i, off while rst_ni is low.
`define TINT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TINT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/tint_pkg.sv =====
// Types, codes and constants of the table interpolator.
`default_nettype none
package tint_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CURV_DIVISOR = 6;
  localparam int MUL_W        = 34;
  localparam int PROD_W       = 68;
  localparam int DIVD_W       = 48;
  localparam int DIVS_W       = 33;
  localparam int ITER_W       = 6;

  // ceil(2^20 / 6): exact quotient by six for any value below 2^19
  localparam logic [17:0] RECIP6       = 18'd174763;
  localparam int          RECIP6_SHIFT = 20;

  localparam logic [0:0] OP_WRITE = 1'b0;
  localparam logic [0:0] OP_QUERY = 1'b1;

  localparam logic [1:0] CLAMP_NONE  = 2'd0;
  localparam logic [1:0] CLAMP_BELOW = 2'd1;
  localparam logic [1:0] CLAMP_ABOVE = 2'd2;

  localparam logic [1:0] MODE_HOLD   = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_SPLINE = 2'd2;

  localparam logic [0:0] REG_ENTRY_COUNT = 1'b0;
  localparam logic [0:0] REG_MODE        = 1'b1;

  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [0:0]          operation;
    logic [7:0]          entry_index;
    logic signed [31:0]  knot_time;
    logic signed [31:0]  knot_value;
    logic signed [31:0]  knot_curvature;
    logic signed [31:0]  query_time;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [7:0]         segment;
    logic [1:0]         clamped;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] iters;
    logic [DIVS_W-1:0] rem_init;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVD_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHK_LAST, S_CHK_FIRST, S_PROBE, S_RD_LO, S_RD_HI,
    S_B_START, S_B_WAIT, S_MUL0, S_LIN,
    S_SP1, S_SP2, S_SP3, S_SP4, S_SP5, S_SP6, S_SP7, S_SP8, S_SP9, S_SP10,
    S_D6_MUL, S_D6_FIX, S_M1, S_M2, S_M3, S_M4, S_DONE
  } state_e;

  function automatic logic [31:0] sat32(input logic signed [39:0] x);
    logic [31:0] r;
    if (x > 40'sd2147483647) r = SAT_MAX;
    else if (x < -40'sd2147483648) r = SAT_MIN;
    else r = x[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/tint_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module tint_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tint_pkg::div_req_t  req_i,
  output tint_pkg::div_rsp_t  rsp_o
);

  localparam int DW = tint_pkg::DIVD_W;
  localparam int SW = tint_pkg::DIVS_W;

  logic                           busy_q, done_q;
  logic [tint_pkg::ITER_W-1:0]    cnt_q;
  logic [SW-1:0]                  rem_q, dvs_q, rem_next;
  logic [DW-1:0]                  quo_q;
  logic [SW:0]                    trial, diff;
  logic                           ge;

  always_comb begin
    trial    = {rem_q, quo_q[DW-1]};
    ge       = (trial >= {1'b0, dvs_q});
    diff     = trial - {1'b0, dvs_q};
    rem_next = ge ? diff[SW-1:0] : trial[SW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.iters;
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != tint_pkg::ITER_W'(1));
      done_q <= (cnt_q == tint_pkg::ITER_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem_init;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_next;
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule
`default_nettype wire

// ===== design/table_interpolator_top.sv =====
// Knot table with hold, linear and cubic spline evaluation on a shared multiplier.
//
//  port group   | dir | handshake            | payload
//  cfg_*        | in  | cfg_we_i             | cfg_index_i, cfg_data_i
//  in_*         | in  | in_valid_i/in_ready_o | tint_pkg::in_t
//  out_*        | out | out_valid_o/out_ready_i | tint_pkg::out_t
//
// A write item is stored as it transfers and leaves the block idle. A clamped query
// checks the last knot and, when below it, the first knot, then ends; a query inside
// the table also searches for its segment and reads both bracketing knots. Linear and
// spline mode then run the bit-serial divider for 16 steps to get the segment fraction;
// the divide by six takes three reciprocal-multiply digits, each a multiply state and a
// fix state. One probe of the search per table read cycle.
// Reset clears control only; the knot stores hold nothing until written.
// A waiting result sits in the output register while the next item transfers.
`default_nettype none
`include "assert_macros.svh"
module table_interpolator_top #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_index_i,
  input  logic [8:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tint_pkg::in_t     in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tint_pkg::out_t    out_data_o
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int IW  = ((AW > 8) ? AW : 8) + 1;
  localparam int CW  = ((AW + 1) > 9) ? (AW + 1) : 9;
  localparam int FB  = tint_pkg::FRAC_BITS;
  localparam int ONE = 1 << tint_pkg::FRAC_BITS;

  // configuration
  logic [8:0] entry_count_q;
  logic [1:0] mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= 9'd2;
      mode_q        <= tint_pkg::MODE_LINEAR;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tint_pkg::REG_ENTRY_COUNT: entry_count_q <= cfg_data_i;
        tint_pkg::REG_MODE: begin
          // drop the code that names no mode
          if (cfg_data_i[1:0] <= tint_pkg::MODE_SPLINE) mode_q <= cfg_data_i[1:0];
        end
        default: ;
      endcase
    end
  end

  logic [CW-1:0] n_c;
  logic [AW-1:0] last_c;

  always_comb begin
    n_c = CW'(entry_count_q);
    if (n_c == '0) n_c = CW'(1);
    if (n_c > CW'(TABLE_DEPTH)) n_c = CW'(TABLE_DEPTH);
    last_c = AW'(n_c - CW'(1));
  end

  // knot stores
  logic [31:0]        time_mem  [TABLE_DEPTH];
  logic [31:0]        value_mem [TABLE_DEPTH];
  logic [31:0]        curv_mem  [TABLE_DEPTH];
  logic signed [31:0] t_rd_q, v_rd_q, c_rd_q;
  logic [AW-1:0]      rd_addr;
  logic [IW-1:0]      widx;
  logic               mem_we;

  tint_pkg::state_e state_q, state_d;

  assign in_ready_o = (state_q == tint_pkg::S_IDLE);
  assign widx       = IW'(in_data_i.entry_index);
  assign mem_we     = in_valid_i && in_ready_o && (in_data_i.operation == tint_pkg::OP_WRITE)
                      && (widx < IW'(TABLE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      time_mem[widx[AW-1:0]]  <= in_data_i.knot_time;
      value_mem[widx[AW-1:0]] <= in_data_i.knot_value;
      curv_mem[widx[AW-1:0]]  <= in_data_i.knot_curvature;
    end
    t_rd_q <= time_mem[rd_addr];
    v_rd_q <= value_mem[rd_addr];
    c_rd_q <= curv_mem[rd_addr];
  end

  // shared divider
  tint_pkg::div_req_t div_req;
  tint_pkg::div_rsp_t div_rsp;

  tint_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // shared multiplier
  logic signed [tint_pkg::MUL_W-1:0]  mul_a_c, mul_b_c;
  logic signed [tint_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a_c * mul_b_c;
  end

  // datapath registers
  logic signed [31:0]                 query_q, query_d;
  logic [AW-1:0]                      lo_q, lo_d, hi_q, hi_d, cur_q, cur_d;
  logic signed [31:0]                 tlo_q, tlo_d, vlo_q, vlo_d, clo_q, clo_d;
  logic signed [31:0]                 vhi_q, vhi_d, chi_q, chi_d;
  logic signed [32:0]                 h_q, h_d, d_q, d_d;
  logic [16:0]                        b_q, b_d;
  logic signed [tint_pkg::PROD_W-1:0] acc_q, acc_d;
  logic signed [33:0]                 lin_q, lin_d, s_q, s_d;
  logic signed [17:0]                 ca_q, ca_d, cb_q, cb_d;
  logic                               neg_q, neg_d, over_q, over_d;
  logic [tint_pkg::DIVD_W-1:0]        mag_q, mag_d;
  logic [2:0]                         r6_q, r6_d;
  logic [1:0]                         dig_q, dig_d;
  logic [49:0]                        tmag_q, tmag_d;
  logic [31:0]                        res_q, res_d;
  logic [7:0]                         seg_q, seg_d;
  logic [1:0]                         clamp_q, clamp_d;

  // combinational helpers
  logic [16:0]        a_c;
  logic signed [32:0] vdiff_c;
  logic [AW-1:0]      nlo_c, nhi_c;
  logic signed [51:0] y_c;
  logic [51:0]        ymag_c;
  logic [18:0]        v6_c;
  logic [15:0]        q6_c;
  logic [80:0]        total_c;
  logic [50:0]        tr_c;
  logic [34:0]        tsh_c;
  logic signed [35:0] t_c;
  logic               out_load;

  assign a_c     = 17'(ONE) - b_q;
  assign vdiff_c = {vhi_q[31], vhi_q} - {vlo_q[31], vlo_q};

  always_comb begin
    state_d  = state_q;
    query_d  = query_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    cur_d    = cur_q;
    tlo_d    = tlo_q;
    vlo_d    = vlo_q;
    clo_d    = clo_q;
    vhi_d    = vhi_q;
    chi_d    = chi_q;
    h_d      = h_q;
    d_d      = d_q;
    b_d      = b_q;
    acc_d    = acc_q;
    lin_d    = lin_q;
    s_d      = s_q;
    ca_d     = ca_q;
    cb_d     = cb_q;
    neg_d    = neg_q;
    over_d   = over_q;
    mag_d    = mag_q;
    r6_d     = r6_q;
    dig_d    = dig_q;
    tmag_d   = tmag_q;
    res_d    = res_q;
    seg_d    = seg_q;
    clamp_d  = clamp_q;
    rd_addr  = lo_q;
    mul_a_c  = '0;
    mul_b_c  = '0;
    div_req  = '0;
    out_load = 1'b0;
    nlo_c    = lo_q;
    nhi_c    = hi_q;
    y_c      = 52'(prod_q >>> FB);
    ymag_c   = y_c[51] ? (52'(-y_c) + 52'(tint_pkg::CURV_DIVISOR - 1)) : 52'(y_c);
    v6_c     = {r6_q, mag_q[tint_pkg::DIVD_W-1:tint_pkg::DIVD_W-16]};
    q6_c     = prod_q[tint_pkg::RECIP6_SHIFT+15:tint_pkg::RECIP6_SHIFT];
    total_c  = {17'd0, acc_q[63:0]} + {prod_q[48:0], 32'd0};
    tr_c     = neg_q ? (51'(tmag_q) + 51'(ONE - 1)) : 51'(tmag_q);
    tsh_c    = 35'(tr_c >> FB);
    t_c      = neg_q ? -36'(tsh_c) : 36'(tsh_c);

    case (state_q)
      tint_pkg::S_IDLE: begin
        rd_addr = last_c;
        if (in_valid_i && in_data_i.operation == tint_pkg::OP_QUERY) begin
          query_d = in_data_i.query_time;
          state_d = tint_pkg::S_CHK_LAST;
        end
      end
      tint_pkg::S_CHK_LAST: begin
        if (query_q >= t_rd_q) begin
          res_d   = v_rd_q;
          seg_d   = 8'(last_c);
          clamp_d = tint_pkg::CLAMP_ABOVE;
          state_d = tint_pkg::S_DONE;
        end else begin
          rd_addr = '0;
          state_d = tint_pkg::S_CHK_FIRST;
        end
      end
      tint_pkg::S_CHK_FIRST: begin
        if (query_q <= t_rd_q) begin
          res_d   = v_rd_q;
          seg_d   = 8'd0;
          clamp_d = tint_pkg::CLAMP_BELOW;
          state_d = tint_pkg::S_DONE;
        end else begin
          lo_d    = '0;
          hi_d    = last_c;
          clamp_d = tint_pkg::CLAMP_NONE;
          if (last_c == AW'(1)) begin
            rd_addr = '0;
            state_d = tint_pkg::S_RD_LO;
          end else begin
            cur_d   = last_c >> 1;
            rd_addr = last_c >> 1;
            state_d = tint_pkg::S_PROBE;
          end
        end
      end
      tint_pkg::S_PROBE: begin
        if (t_rd_q <= query_q) nlo_c = cur_q;
        else nhi_c = cur_q;
        lo_d = nlo_c;
        hi_d = nhi_c;
        if ((nhi_c - nlo_c) == AW'(1)) begin
          rd_addr = nlo_c;
          state_d = tint_pkg::S_RD_LO;
        end else begin
          cur_d   = nlo_c + ((nhi_c - nlo_c) >> 1);
          rd_addr = nlo_c + ((nhi_c - nlo_c) >> 1);
        end
      end
      tint_pkg::S_RD_LO: begin
        tlo_d   = t_rd_q;
        vlo_d   = v_rd_q;
        clo_d   = c_rd_q;
        rd_addr = hi_q;
        state_d = tint_pkg::S_RD_HI;
      end
      tint_pkg::S_RD_HI: begin
        vhi_d = v_rd_q;
        chi_d = c_rd_q;
        h_d   = {t_rd_q[31], t_rd_q} - {tlo_q[31], tlo_q};
        d_d   = {query_q[31], query_q} - {tlo_q[31], tlo_q};
        seg_d = 8'(lo_q);
        if (mode_q == tint_pkg::MODE_HOLD) begin
          res_d   = vlo_q;
          state_d = tint_pkg::S_DONE;
        end else begin
          state_d = tint_pkg::S_B_START;
        end
      end
      tint_pkg::S_B_START: begin
        // the bracket keeps 0 <= d < h, so the fraction needs FRAC_BITS steps
        div_req.start    = 1'b1;
        div_req.iters    = tint_pkg::ITER_W'(FB);
        div_req.rem_init = d_q;
        div_req.divisor  = h_q;
        state_d          = tint_pkg::S_B_WAIT;
      end
      tint_pkg::S_B_WAIT: begin
        if (div_rsp.done) begin
          b_d     = 17'(div_rsp.quot[FB-1:0]);
          state_d = tint_pkg::S_MUL0;
        end
      end
      tint_pkg::S_MUL0: begin
        if (mode_q == tint_pkg::MODE_LINEAR) begin
          mul_a_c = 34'(vdiff_c);
          mul_b_c = 34'(b_q);
          state_d = tint_pkg::S_LIN;
        end else begin
          mul_a_c = 34'(a_c);
          mul_b_c = 34'(vlo_q);
          state_d = tint_pkg::S_SP1;
        end
      end
      tint_pkg::S_LIN: begin
        res_d   = tint_pkg::sat32(40'(vlo_q) + 40'(prod_q >>> FB));
        state_d = tint_pkg::S_DONE;
      end
      tint_pkg::S_SP1: begin
        acc_d   = prod_q;
        mul_a_c = 34'(b_q);
        mul_b_c = 34'(vhi_q);
        state_d = tint_pkg::S_SP2;
      end
      tint_pkg::S_SP2: begin
        lin_d   = 34'((acc_q + prod_q) >>> FB);
        mul_a_c = 34'(a_c);
        mul_b_c = 34'(a_c);
        state_d = tint_pkg::S_SP3;
      end
      tint_pkg::S_SP3: begin
        mul_a_c = 34'(prod_q[FB+16:FB]);
        mul_b_c = 34'(a_c);
        state_d = tint_pkg::S_SP4;
      end
      tint_pkg::S_SP4: begin
        ca_d    = 18'(prod_q[FB+16:FB]) - 18'(a_c);
        mul_a_c = 34'(b_q);
        mul_b_c = 34'(b_q);
        state_d = tint_pkg::S_SP5;
      end
      tint_pkg::S_SP5: begin
        mul_a_c = 34'(prod_q[FB+16:FB]);
        mul_b_c = 34'(b_q);
        state_d = tint_pkg::S_SP6;
      end
      tint_pkg::S_SP6: begin
        cb_d    = 18'(prod_q[FB+16:FB]) - 18'(b_q);
        mul_a_c = 34'(ca_q);
        mul_b_c = 34'(clo_q);
        state_d = tint_pkg::S_SP7;
      end
      tint_pkg::S_SP7: begin
        acc_d   = prod_q;
        mul_a_c = 34'(cb_q);
        mul_b_c = 34'(chi_q);
        state_d = tint_pkg::S_SP8;
      end
      tint_pkg::S_SP8: begin
        s_d     = 34'((acc_q + prod_q) >>> FB);
        state_d = tint_pkg::S_SP9;
      end
      tint_pkg::S_SP9: begin
        mul_a_c = s_q;
        mul_b_c = 34'(h_q);
        state_d = tint_pkg::S_SP10;
      end
      tint_pkg::S_SP10: begin
        // floor divide by six on the magnitude, biased up when negative
        neg_d   = y_c[51];
        mag_d   = ymag_c[tint_pkg::DIVD_W-1:0];
        r6_d    = '0;
        dig_d   = '0;
        state_d = tint_pkg::S_D6_MUL;
      end
      tint_pkg::S_D6_MUL: begin
        // long division in 16-bit digits, remainder carried into the next digit
        mul_a_c = 34'(v6_c);
        mul_b_c = 34'(tint_pkg::RECIP6);
        state_d = tint_pkg::S_D6_FIX;
      end
      tint_pkg::S_D6_FIX: begin
        r6_d  = 3'(v6_c - 19'({q6_c, 2'b00}) - 19'({q6_c, 1'b0}));
        mag_d = {mag_q[tint_pkg::DIVD_W-17:0], q6_c};
        dig_d = dig_q + 2'd1;
        if (dig_q == 2'd2) state_d = tint_pkg::S_M1;
        else state_d = tint_pkg::S_D6_MUL;
      end
      tint_pkg::S_M1: begin
        mul_a_c = 34'(mag_q[31:0]);
        mul_b_c = 34'(h_q);
        state_d = tint_pkg::S_M2;
      end
      tint_pkg::S_M2: begin
        acc_d   = prod_q;
        mul_a_c = 34'(mag_q[tint_pkg::DIVD_W-1:32]);
        mul_b_c = 34'(h_q);
        state_d = tint_pkg::S_M3;
      end
      tint_pkg::S_M3: begin
        // |P|*h above 2^(33+F) saturates at once
        over_d  = (total_c[80:50] != '0) || (total_c[49] && (total_c[48:0] != '0));
        tmag_d  = total_c[49:0];
        state_d = tint_pkg::S_M4;
      end
      tint_pkg::S_M4: begin
        if (over_q) res_d = neg_q ? tint_pkg::SAT_MIN : tint_pkg::SAT_MAX;
        else res_d = tint_pkg::sat32(40'(lin_q) + 40'(t_c));
        state_d = tint_pkg::S_DONE;
      end
      tint_pkg::S_DONE: begin
        if (!out_valid_o || out_ready_i) begin
          out_load = 1'b1;
          state_d  = tint_pkg::S_IDLE;
        end
      end
      default: state_d = tint_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= tint_pkg::S_IDLE;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    query_q <= query_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    cur_q   <= cur_d;
    tlo_q   <= tlo_d;
    vlo_q   <= vlo_d;
    clo_q   <= clo_d;
    vhi_q   <= vhi_d;
    chi_q   <= chi_d;
    h_q     <= h_d;
    d_q     <= d_d;
    b_q     <= b_d;
    acc_q   <= acc_d;
    lin_q   <= lin_d;
    s_q     <= s_d;
    ca_q    <= ca_d;
    cb_q    <= cb_d;
    neg_q   <= neg_d;
    over_q  <= over_d;
    mag_q   <= mag_d;
    r6_q    <= r6_d;
    dig_q   <= dig_d;
    tmag_q  <= tmag_d;
    res_q   <= res_d;
    seg_q   <= seg_d;
    clamp_q <= clamp_d;
  end

  // output register
  logic           out_valid_q;
  tint_pkg::out_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (out_load) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.result_value <= res_q;
      out_data_q.segment      <= seg_q;
      out_data_q.clamped      <= clamp_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `TINT_ASSERT_IMPL(a_probe_bracket, state_q == tint_pkg::S_PROBE, lo_q < hi_q,
                    "search bracket collapsed")
  `TINT_ASSERT_IMPL(a_div_start_idle, div_req.start, !div_rsp.busy,
                    "divider restarted while busy")
  `TINT_ASSERT_IMPL(a_div_done_wait, div_rsp.done,
                    state_q == tint_pkg::S_B_WAIT || state_q == tint_pkg::S_D6_MUL,
                    "divider finished outside a wait state")
  `TINT_ASSERT_IMPL(a_ready_div_idle, in_ready_o, !div_rsp.busy,
                    "ready while divider busy")
  `TINT_ASSERT(a_clamp_code, !out_valid_o || out_data_o.clamped == tint_pkg::CLAMP_NONE
               || out_data_o.clamped == tint_pkg::CLAMP_BELOW
               || out_data_o.clamped == tint_pkg::CLAMP_ABOVE, "bad clamp code")

endmodule
`default_nettype wire
